@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition in one cycle implies another in the same cycle.
`define ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

@@ design/met_pkg.sv @@
package met_pkg;

	localparam int ROW_W       = 12;
	localparam int COL_W       = 12;
	localparam int ITER_W      = 16;
	localparam int COLOR_W     = 8;
	localparam int COLOR_SHIFT = 24;
	localparam int FX_W        = 64;
	localparam int MAG_W       = 63;
	localparam int ACC_W       = 128;
	localparam int SHIFT_W     = 32;
	localparam int STEP_W      = 58;
	localparam int OFF_W       = 34;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 58;
	localparam int IN_W        = 24;
	localparam int OUT_W       = 40;
	localparam int DIV_STEPS   = ITER_W + COLOR_SHIFT;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [1:0] PHASE_LAST = 2'd3;

	localparam logic [FX_W-1:0]  FX_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [FX_W-1:0]  FX_MIN  = 64'h8000_0000_0000_0001;
	localparam logic [MAG_W-1:0] MAG_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [SHIFT_W-1:0] SHIFT_X_RST  = 32'd960;
	localparam logic [SHIFT_W-1:0] SHIFT_Y_RST  = 32'd540;
	localparam logic [STEP_W-1:0]  STEP_RST     = 58'd1441151880758559;
	localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHIFT_X    = 2'd0,
		CFG_SHIFT_Y    = 2'd1,
		CFG_PIXEL_STEP = 2'd2,
		CFG_MAX_ITER   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic       en;
		logic [1:0] phase;
		logic       plane;
	} lane_ctl_t;

	typedef struct packed {
		logic      load;
		lane_ctl_t mul;
		logic      store;
		logic      add;
		logic      div_init;
		logic      div_step;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic escape;
		logic count_full;
		logic out_busy;
	} sts_t;

endpackage

@@ design/met_mul_lane.sv @@
module met_mul_lane #(
	parameter int FRAC_BITS = 58
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  met_pkg::lane_ctl_t            ctl,
	input  logic                          neg,
	input  logic [met_pkg::MAG_W-1:0]     a,
	input  logic [met_pkg::MAG_W-1:0]     b,
	output logic [met_pkg::FX_W-1:0]      res
);

	localparam int HALF = 32;
	localparam int HI_W = met_pkg::MAG_W - HALF;

	logic [HALF-1:0]               a_part;
	logic [HALF-1:0]               b_part;
	logic [2*HALF-1:0]             pp_s1;
	logic [1:0]                    sh_s1;
	logic                          vld_s1;
	logic [met_pkg::ACC_W-1:0]     acc_q;
	logic [met_pkg::ACC_W-1:0]     pp_shifted;
	logic                          clr;
	logic                          plane_q;
	logic                          neg_q;
	logic [met_pkg::MAG_W-1:0]     mag;

	assign a_part = ctl.phase[1] ? {1'b0, a[met_pkg::MAG_W-1:HALF]} : a[HALF-1:0];
	assign b_part = ctl.phase[0] ? {1'b0, b[met_pkg::MAG_W-1:HALF]} : b[HALF-1:0];
	assign clr    = ctl.en && (ctl.phase == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.en;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= a_part * b_part;
		sh_s1 <= 2'({1'b0, ctl.phase[1]} + {1'b0, ctl.phase[0]});
		if (clr) begin
			plane_q <= ctl.plane;
			neg_q   <= neg;
		end
		acc_q <= (clr ? '0 : acc_q) + (vld_s1 ? pp_shifted : '0);
	end

	always_comb begin
		case (sh_s1)
			2'd0:    pp_shifted = {64'd0, pp_s1};
			2'd1:    pp_shifted = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_shifted = {pp_s1, 64'd0};
			default: pp_shifted = '0;
		endcase
	end

	always_comb begin
		if (plane_q) begin
			mag = (|acc_q[met_pkg::ACC_W-1:met_pkg::MAG_W]) ?
				met_pkg::MAG_MAX : acc_q[met_pkg::MAG_W-1:0];
		end else begin
			mag = (|acc_q[met_pkg::ACC_W-1:FRAC_BITS+met_pkg::MAG_W]) ?
				met_pkg::MAG_MAX : acc_q[FRAC_BITS+met_pkg::MAG_W-1:FRAC_BITS];
		end
	end

	assign res = neg_q ? (64'd0 - {1'b0, mag}) : {1'b0, mag};

	logic unused_hi;
	assign unused_hi = (HI_W == 0);

endmodule

@@ design/met_ctrl.sv @@
module met_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  met_pkg::sts_t   sts,
	output met_pkg::cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_DRAIN = 8'b0000_0100,
		S_STORE = 8'b0000_1000,
		S_CHECK = 8'b0001_0000,
		S_ADD   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [1:0]                      phase_q;
	logic [1:0]                      phase_d;
	logic                            plane_q;
	logic                            plane_d;
	logic [met_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [met_pkg::DIV_CNT_W-1:0]   div_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= 2'd0;
			plane_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			plane_q   <= plane_d;
			div_cnt_q <= div_cnt_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		plane_d       = plane_q;
		div_cnt_d     = div_cnt_q;
		cmd           = '0;
		cmd.mul.plane = plane_q;
		cmd.mul.phase = phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					plane_d  = 1'b1;
					phase_d  = 2'd0;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul.en = 1'b1;
				phase_d    = phase_q + 2'd1;
				if (phase_q == met_pkg::PHASE_LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_STORE;
			end
			S_STORE: begin
				cmd.store = 1'b1;
				plane_d   = 1'b0;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (sts.escape || sts.count_full) begin
					cmd.div_init = 1'b1;
					div_cnt_d    = '0;
					state_d      = S_DIV;
				end else begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				phase_d = 2'd0;
				state_d = S_MUL;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + 1'b1;
				if (div_cnt_q == met_pkg::DIV_CNT_W'(met_pkg::DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/met_dp.sv @@
module met_dp #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 58
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [met_pkg::IN_W-1:0]          s_tdata,
	input  met_pkg::cmd_t                     cmd,
	output met_pkg::sts_t                     sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [met_pkg::OUT_W-1:0]         m_tdata
);

	localparam int CB = (COORD_BITS < met_pkg::ROW_W) ? COORD_BITS : met_pkg::ROW_W;
	localparam logic [met_pkg::ROW_W-1:0] CMASK = met_pkg::ROW_W'((64'd1 << CB) - 64'd1);
	localparam logic [met_pkg::FX_W-1:0]  LIMIT = 64'd4 << FRAC_BITS;
	localparam int DQ_W = met_pkg::DIV_STEPS;

	function automatic logic [met_pkg::FX_W-1:0] sat_add(
		input logic [met_pkg::FX_W-1:0] a,
		input logic [met_pkg::FX_W-1:0] b
	);
		logic [met_pkg::FX_W:0] s;
		s = {a[met_pkg::FX_W-1], a} + {b[met_pkg::FX_W-1], b};
		if (!s[64] && s[63]) begin
			sat_add = met_pkg::FX_MAX;
		end else if (s[64] && (!s[63] || s[62:0] == 63'd0)) begin
			sat_add = met_pkg::FX_MIN;
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	logic [met_pkg::SHIFT_W-1:0]   shift_x_q;
	logic [met_pkg::SHIFT_W-1:0]   shift_y_q;
	logic [met_pkg::STEP_W-1:0]    step_q;
	logic [met_pkg::ITER_W-1:0]    max_iter_q;

	logic [met_pkg::ROW_W-1:0]     row_m;
	logic [met_pkg::COL_W-1:0]     col_m;
	logic [met_pkg::OFF_W-1:0]     off_x;
	logic [met_pkg::OFF_W-1:0]     off_y;
	logic [met_pkg::OFF_W-1:0]     neg_off_x;
	logic [met_pkg::OFF_W-1:0]     neg_off_y;
	logic [met_pkg::OFF_W-2:0]     ox_mag_q;
	logic [met_pkg::OFF_W-2:0]     oy_mag_q;
	logic                          ox_neg_q;
	logic                          oy_neg_q;

	logic [met_pkg::FX_W-1:0]      cr_q;
	logic [met_pkg::FX_W-1:0]      ci_q;
	logic [met_pkg::FX_W-1:0]      x_q;
	logic [met_pkg::FX_W-1:0]      y_q;
	logic [met_pkg::FX_W-1:0]      xx_q;
	logic [met_pkg::FX_W-1:0]      yy_q;
	logic [met_pkg::FX_W-1:0]      p_q;
	logic [met_pkg::FX_W-1:0]      dxy_q;
	logic [met_pkg::FX_W-1:0]      p2_q;
	logic [met_pkg::ITER_W-1:0]    n_q;

	logic [met_pkg::FX_W-1:0]      neg_x;
	logic [met_pkg::FX_W-1:0]      neg_y;
	logic [met_pkg::MAG_W-1:0]     x_mag;
	logic [met_pkg::MAG_W-1:0]     y_mag;
	logic [met_pkg::MAG_W-1:0]     a0;
	logic [met_pkg::MAG_W-1:0]     b0;
	logic [met_pkg::MAG_W-1:0]     a1;
	logic [met_pkg::MAG_W-1:0]     b1;
	logic                          neg0;
	logic                          neg1;
	logic                          neg2;
	logic [met_pkg::FX_W-1:0]      r0;
	logic [met_pkg::FX_W-1:0]      r1;
	logic [met_pkg::FX_W-1:0]      r2;
	logic [met_pkg::FX_W-1:0]      esc_sum;

	logic [met_pkg::ITER_W-1:0]    rem_q;
	logic [DQ_W-1:0]               dq_q;
	logic [met_pkg::ITER_W:0]      trial;
	logic [met_pkg::ITER_W:0]      trial_sub;
	logic                          ge;
	logic [met_pkg::COLOR_SHIFT-1:0] v;

	logic                          out_valid_q;
	logic [met_pkg::ITER_W-1:0]    iter_q;
	logic [met_pkg::COLOR_W-1:0]   red_q;
	logic [met_pkg::COLOR_W-1:0]   green_q;
	logic [met_pkg::COLOR_W-1:0]   blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q  <= met_pkg::SHIFT_X_RST;
			shift_y_q  <= met_pkg::SHIFT_Y_RST;
			step_q     <= met_pkg::STEP_RST;
			max_iter_q <= met_pkg::MAX_ITER_RST;
		end else if (cfg_we) begin
			unique case (met_pkg::cfg_idx_t'(cfg_index))
				met_pkg::CFG_SHIFT_X:    shift_x_q  <= cfg_data[met_pkg::SHIFT_W-1:0];
				met_pkg::CFG_SHIFT_Y:    shift_y_q  <= cfg_data[met_pkg::SHIFT_W-1:0];
				met_pkg::CFG_PIXEL_STEP: step_q     <= cfg_data[met_pkg::STEP_W-1:0];
				met_pkg::CFG_MAX_ITER:   max_iter_q <= cfg_data[met_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	assign row_m = s_tdata[met_pkg::ROW_W-1:0] & CMASK;
	assign col_m = s_tdata[met_pkg::IN_W-1:met_pkg::ROW_W] & CMASK;

	assign off_x = {22'd0, col_m} - {{2{shift_x_q[met_pkg::SHIFT_W-1]}}, shift_x_q};
	assign off_y = {22'd0, row_m} - {{2{shift_y_q[met_pkg::SHIFT_W-1]}}, shift_y_q};
	assign neg_off_x = '0 - off_x;
	assign neg_off_y = '0 - off_y;

	assign neg_x = '0 - x_q;
	assign neg_y = '0 - y_q;
	assign x_mag = x_q[met_pkg::FX_W-1] ? neg_x[met_pkg::MAG_W-1:0] : x_q[met_pkg::MAG_W-1:0];
	assign y_mag = y_q[met_pkg::FX_W-1] ? neg_y[met_pkg::MAG_W-1:0] : y_q[met_pkg::MAG_W-1:0];

	assign a0   = cmd.mul.plane ? met_pkg::MAG_W'(ox_mag_q) : x_mag;
	assign b0   = cmd.mul.plane ? met_pkg::MAG_W'(step_q)   : x_mag;
	assign neg0 = cmd.mul.plane && ox_neg_q;
	assign a1   = cmd.mul.plane ? met_pkg::MAG_W'(oy_mag_q) : y_mag;
	assign b1   = cmd.mul.plane ? met_pkg::MAG_W'(step_q)   : y_mag;
	assign neg1 = cmd.mul.plane && oy_neg_q;
	assign neg2 = x_q[met_pkg::FX_W-1] ^ y_q[met_pkg::FX_W-1];

	met_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_re (
		.clk(clk), .arst_n(arst_n), .ctl(cmd.mul), .neg(neg0), .a(a0), .b(b0), .res(r0)
	);

	met_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_im (
		.clk(clk), .arst_n(arst_n), .ctl(cmd.mul), .neg(neg1), .a(a1), .b(b1), .res(r1)
	);

	met_mul_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_xy (
		.clk(clk), .arst_n(arst_n), .ctl(cmd.mul), .neg(neg2), .a(x_mag), .b(y_mag), .res(r2)
	);

	assign trial     = {rem_q, dq_q[DQ_W-1]};
	assign trial_sub = trial - {1'b0, max_iter_q};
	assign ge        = (trial >= {1'b0, max_iter_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ox_neg_q <= off_x[met_pkg::OFF_W-1];
			oy_neg_q <= off_y[met_pkg::OFF_W-1];
			ox_mag_q <= off_x[met_pkg::OFF_W-1] ? neg_off_x[met_pkg::OFF_W-2:0]
				: off_x[met_pkg::OFF_W-2:0];
			oy_mag_q <= off_y[met_pkg::OFF_W-1] ? neg_off_y[met_pkg::OFF_W-2:0]
				: off_y[met_pkg::OFF_W-2:0];
		end
		if (cmd.store) begin
			if (cmd.mul.plane) begin
				cr_q <= r0;
				ci_q <= r1;
				xx_q <= '0;
				yy_q <= '0;
				p_q  <= '0;
				n_q  <= '0;
			end else begin
				xx_q <= r0;
				yy_q <= r1;
				p_q  <= r2;
				n_q  <= n_q + 1'b1;
			end
		end
		dxy_q <= xx_q - yy_q;
		p2_q  <= sat_add(p_q, p_q);
		if (cmd.add) begin
			x_q <= sat_add(dxy_q, cr_q);
			y_q <= sat_add(p2_q, ci_q);
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dq_q  <= {n_q, 24'd0};
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[met_pkg::ITER_W-1:0] : trial[met_pkg::ITER_W-1:0];
			dq_q  <= {dq_q[DQ_W-2:0], ge};
		end
		if (cmd.out_load) begin
			iter_q  <= n_q;
			red_q   <= v[15:8];
			green_q <= v[7:0];
			blue_q  <= v[23:16];
		end
	end

	assign esc_sum = {1'b0, xx_q[met_pkg::MAG_W-1:0]} + {1'b0, yy_q[met_pkg::MAG_W-1:0]};
	assign v       = (max_iter_q == '0) ? '0 : dq_q[met_pkg::COLOR_SHIFT-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.escape     = (esc_sum > LIMIT);
	assign sts.count_full = (n_q == max_iter_q);
	assign sts.out_busy   = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {blue_q, green_q, red_q, iter_q};

endmodule

@@ design/mandelbrot_escape_time_pixel_core.sv @@
// A request is taken only once the previous result is in the output register. Each
// iteration runs on three product lanes, each with one 32x32 multiplier, which run
// four partial products; the color takes a 40-step restoring divider.
// A finished result waits in the output register while the next request is taken.
// Reset is asynchronous: it idles the control and restores the register defaults.
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 58
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [met_pkg::IN_W-1:0]          s_tdata,   // row, col
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [met_pkg::OUT_W-1:0]         m_tdata,   // iterations, red, green, blue
	input  logic                              cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data
);

	met_pkg::cmd_t cmd;
	met_pkg::sts_t sts;

	met_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	met_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Only one request is in work at a time.
	`ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)
	// A new result never overwrites one that has not been taken.
	`ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready)
	// A zero count only comes from a zero limit, which gives black.
	`ASSERT_IMPL(a_zero_black, m_tvalid && m_tdata[15:0] == 16'd0, m_tdata[39:16] == 24'd0)

endmodule

@@ test/escape_color_checker.sv @@
module escape_color_checker
	import met_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,    // row, col
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_W-1:0]      m_tdata,    // iterations, red, green, blue
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	localparam int FRAC = 58;
	localparam logic [64:0] ESCAPE_BOUND = 65'd4 << FRAC;
	localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;

	typedef logic signed [FX_W-1:0] fx_t;

	typedef struct packed {
		logic [ITER_W-1:0]  iterations;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_color_t;

	logic signed [SHIFT_W-1:0] shift_x;
	logic signed [SHIFT_W-1:0] shift_y;
	logic [STEP_W-1:0]         pixel_step;
	logic [ITER_W-1:0]         max_iter;
	pixel_color_t              expected_colors[$];
	pixel_color_t              oldest;

	function automatic logic [FX_W-1:0] magnitude(fx_t a);
		return a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
	endfunction

	function automatic fx_t clamp_sign(logic [FX_W-1:0] m, logic neg);
		if (m > FX_MAX) begin
			m = FX_MAX;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic fx_t fx_product(fx_t a, fx_t b);
		logic [127:0]    p;
		logic [FX_W-1:0] m;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		if (|p[127:FRAC+64]) begin
			m = FX_MAX;
		end else begin
			m = p[FRAC+63:FRAC];
		end
		return clamp_sign(m, a[FX_W-1] ^ b[FX_W-1]);
	endfunction

	function automatic fx_t fx_sum(fx_t a, fx_t b);
		logic signed [64:0] s;
		s = a + b;
		if (s > SUM_HI) begin
			return FX_MAX;
		end else if (s < -SUM_HI) begin
			return FX_MIN;
		end
		return s[FX_W-1:0];
	endfunction

	function automatic fx_t plane_coord(logic [ROW_W-1:0] pix, logic signed [SHIFT_W-1:0] shift);
		fx_t             off;
		logic [127:0]    p;
		logic [FX_W-1:0] m;
		off = $signed({52'd0, pix}) - shift;
		p = {64'd0, magnitude(off)} * {70'd0, pixel_step};
		m = (p[127:64] != 0) ? FX_MAX : p[63:0];
		return clamp_sign(m, off[FX_W-1]);
	endfunction

	function automatic pixel_color_t escape_time(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		fx_t               cr, ci, x, y, xx, yy, p;
		logic [ITER_W-1:0] n;
		logic [39:0]       v;
		logic              escaped;
		pixel_color_t      c;
		cr = plane_coord(col, shift_x);
		ci = plane_coord(row, shift_y);
		x = '0;
		y = '0;
		xx = '0;
		yy = '0;
		n = '0;
		escaped = 1'b0;
		while (!escaped && n < max_iter) begin
			p = fx_product(x, y);
			y = fx_sum(fx_sum(p, p), ci);
			x = fx_sum(xx - yy, cr);
			xx = fx_product(x, x);
			yy = fx_product(y, y);
			n = n + 1'b1;
			escaped = ({1'b0, xx} + {1'b0, yy}) > ESCAPE_BOUND;
		end
		v = (max_iter == 0) ? 40'd0 : {n, 24'd0} / {24'd0, max_iter};
		c.iterations = n;
		c.red = v[15:8];
		c.green = v[7:0];
		c.blue = v[23:16];
		return c;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		if (mismatches < 100) begin
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x = SHIFT_X_RST;
			shift_y = SHIFT_Y_RST;
			pixel_step = STEP_RST;
			max_iter = MAX_ITER_RST;
			expected_colors.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("result with no request pending", 0, m_tdata[15:0]);
				end else begin
					oldest = expected_colors.pop_front();
					if (m_tdata[15:0] !== oldest.iterations)
						report_mismatch("iterations", oldest.iterations, m_tdata[15:0]);
					if (m_tdata[23:16] !== oldest.red)
						report_mismatch("red", oldest.red, m_tdata[23:16]);
					if (m_tdata[31:24] !== oldest.green)
						report_mismatch("green", oldest.green, m_tdata[31:24]);
					if (m_tdata[39:32] !== oldest.blue)
						report_mismatch("blue", oldest.blue, m_tdata[39:32]);
				end
			end
			if (s_tvalid && s_tready) begin
				expected_colors.push_back(escape_time(s_tdata[11:0], s_tdata[23:12]));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHIFT_X:    shift_x = cfg_data[SHIFT_W-1:0];
					CFG_SHIFT_Y:    shift_y = cfg_data[SHIFT_W-1:0];
					CFG_PIXEL_STEP: pixel_step = cfg_data[STEP_W-1:0];
					CFG_MAX_ITER:   max_iter = cfg_data[ITER_W-1:0];
				endcase
			end
			pending <= expected_colors.size();
		end
	end

endmodule

@@ test/mandelbrot_escape_time_pixel_core_tb.sv @@
module mandelbrot_escape_time_pixel_core_tb;
	import met_pkg::*;

	localparam logic [STEP_W-1:0] STEP_FULL = '1;
	localparam logic [STEP_W:0]   UNIT_STEP = 59'd1 << 58;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_SHIFT_X;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches;
	int                    pending;
	int                    send_pct = 0;
	int                    recv_pct = 0;

	mandelbrot_escape_time_pixel_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	escape_color_checker color_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int burst;
		bit hold;
		burst = 0;
		hold = 1'b0;
		forever begin
			@(posedge clk);
			if (burst == 0) begin
				burst = $urandom_range(1, 32);
				hold = $urandom_range(99) < recv_pct;
			end
			burst--;
			m_tready <= !hold;
		end
	end

	task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		if ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 64)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic load_view(input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy,
			input logic [STEP_W-1:0] step, input logic [ITER_W-1:0] iter_cap);
		drain_pixels();
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHIFT_X;
		cfg_data <= CFG_DATA_W'(sx);
		@(posedge clk);
		cfg_index <= CFG_SHIFT_Y;
		cfg_data <= CFG_DATA_W'(sy);
		@(posedge clk);
		cfg_index <= CFG_PIXEL_STEP;
		cfg_data <= CFG_DATA_W'(step);
		@(posedge clk);
		cfg_index <= CFG_MAX_ITER;
		cfg_data <= CFG_DATA_W'(iter_cap);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int kind;
		int i;
		logic [SHIFT_W-1:0] sx;
		logic [SHIFT_W-1:0] sy;
		logic [STEP_W-1:0]  step;
		logic [ITER_W-1:0]  iter_cap;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(540, 960);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(0, 4095);
		send_pixel(4095, 0);
		send_pixel(540, 860);
		send_pixel(540, 1020);
		send_pixel(560, 810);

		load_view(960, 540, STEP_RST, 0);
		send_pixel(540, 960);
		send_pixel(4095, 0);

		load_view(960, 540, STEP_RST, 1);
		send_pixel(540, 960);

		load_view(100, 200, '0, 7);
		send_pixel(123, 456);

		load_view(32'h8000_0000, 32'h7FFF_FFFF, STEP_FULL, 16'hFFFF);
		send_pixel(0, 0);
		send_pixel(4095, 4095);

		load_view(32'h7FFF_FFFF, 32'h8000_0000, STEP_FULL, 16'hFFFF);
		send_pixel(4095, 0);

		load_view(5, 5, STEP_FULL, 20);
		send_pixel(5, 6);
		send_pixel(6, 5);
		send_pixel(5, 5);

		for (phase = 0; phase < 24; phase++) begin
			case (phase % 4)
				0: begin
					send_pct = 0;
					recv_pct = 0;
				end
				1: begin
					send_pct = 65;
					recv_pct = 0;
				end
				2: begin
					send_pct = 0;
					recv_pct = 65;
				end
				default: begin
					send_pct = 24;
					recv_pct = 24;
				end
			endcase

			kind = $urandom_range(9);
			sx = 1024 + $urandom_range(2047);
			sy = 1024 + $urandom_range(2047);
			step = UNIT_STEP / $urandom_range(256, 4096);
			iter_cap = $urandom_range(1, 48);
			case (kind)
				6: begin
					sx = $urandom;
					sy = $urandom;
					step = {$urandom, $urandom};
				end
				7: step = $urandom_range(1 << 20);
				8: begin
					sx = $urandom;
					sy = $urandom;
				end
				9: begin
					sx = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					sy = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					step = $urandom_range(1) ? '0 : STEP_FULL;
					iter_cap = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 16));
				end
				default: ;
			endcase
			if ($urandom_range(11) == 0) begin
				iter_cap = '0;
			end
			if (phase == 0) begin
				load_view(SHIFT_X_RST, SHIFT_Y_RST, STEP_RST, MAX_ITER_RST);
			end else begin
				load_view(sx, sy, step, iter_cap);
			end

			for (i = 0; i < 50; i++) begin
				send_pixel($urandom_range(4095), $urandom_range(4095));
			end
		end

		drain_pixels();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/met_pkg.sv
design/met_mul_lane.sv
design/met_ctrl.sv
design/met_dp.sv
design/mandelbrot_escape_time_pixel_core.sv
test/escape_color_checker.sv
test/mandelbrot_escape_time_pixel_core_tb.sv
